/* hw/rtl/qrr_pkg.sv */
package qrr_pkg;

	localparam int ROOT_FRAC_BITS_DEF = 16;
	localparam int SQRT_EXTRA = 14;
	localparam int DISC_W = 33;
	localparam int SQRT_W = 31;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_DOUBLE = 2'd1,
		KIND_TWO    = 2'd2,
		KIND_A_ZERO = 2'd3
	} kind_t;

	typedef struct packed {
		logic signed [15:0] coef_a;
		logic signed [15:0] coef_b;
		logic signed [15:0] coef_c;
	} in_t;

	typedef struct packed {
		logic [1:0]         root_kind;
		logic signed [31:0] root_high;
		logic signed [31:0] root_low;
		logic               saturated;
	} out_t;

	typedef struct packed {
		kind_t              kind;
		logic [DISC_W-1:0]  disc;
		logic signed [15:0] a;
		logic signed [15:0] b;
	} mid_t;

	typedef struct packed {
		logic mid_pop;
		logic out_push;
	} back_ctl_t;

endpackage

/* hw/rtl/quadratic_real_roots_core.sv */
// Path from an input transfer to the result showing on the output queue:
// 1 more front stage after the transfer edge, 1 queue, 31 square-root stages,
// 2 setup stages, 32 divider stages, 1 queue.
// Throughput: one item per cycle; the square-root and divider pipelines take a new item
// every cycle and stall as one when the output queue is full.
// Reset: arst_n clears all valid bits and queue pointers at once; no clearing pass.
module quadratic_real_roots_core import qrr_pkg::*; #(
	parameter int ROOT_FRAC_BITS = ROOT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic empty,
	input  logic pop,
	output out_t result
);
	logic      mid_full, mid_empty, mid_push;
	mid_t      mid_wr, mid_rd;
	logic      out_full;
	back_ctl_t ctl;
	out_t      back_item;

	qrr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_item (mid_wr)
	);

	qrr_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wr),
		.pop    (ctl.mid_pop),
		.rdata  (mid_rd),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	qrr_back #(.ROOT_FRAC_BITS(ROOT_FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_item  (mid_rd),
		.mid_empty (mid_empty),
		.out_full  (out_full),
		.ctl       (ctl),
		.out_item  (back_item)
	);

	qrr_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ctl.out_push),
		.wdata  (back_item),
		.pop    (pop),
		.rdata  (result),
		.full   (out_full),
		.empty  (empty)
	);
endmodule

/* hw/rtl/qrr_fifo.sv */
module qrr_fifo import qrr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

/* hw/rtl/qrr_front.sv */
module qrr_front import qrr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	input  logic mid_full,
	output logic mid_push,
	output mid_t mid_item
);
	logic               en;
	logic               v_s1, v_s2;
	logic signed [15:0] a_s1, b_s1;
	logic signed [31:0] bb_s1, ac_s1;
	logic signed [34:0] d;
	mid_t               mid_s2;

	// advance unless a finished item is blocked at the queue
	assign en       = !(v_s2 && mid_full);
	assign full     = !en;
	assign mid_push = v_s2 && en;
	assign mid_item = mid_s2;

	assign d = 35'(bb_s1) - (35'(ac_s1) <<< 2);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= item.coef_a;
			b_s1  <= item.coef_b;
			bb_s1 <= item.coef_b * item.coef_b;
			ac_s1 <= item.coef_a * item.coef_c;
			mid_s2.a    <= a_s1;
			mid_s2.b    <= b_s1;
			mid_s2.disc <= d[DISC_W-1:0];
			priority if (a_s1 == '0) begin
				mid_s2.kind <= KIND_A_ZERO;
			end else if (d[34]) begin
				mid_s2.kind <= KIND_NONE;
			end else if (d == '0) begin
				mid_s2.kind <= KIND_DOUBLE;
			end else begin
				mid_s2.kind <= KIND_TWO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end
endmodule

/* hw/rtl/qrr_sqrt.sv */
module qrr_sqrt import qrr_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DISC_W-1:0] disc,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [SQRT_W-1:0] root,
	output logic [SIDE_W-1:0] out_side
);
	localparam int NS    = SQRT_W;
	localparam int RAD_W = 2 * SQRT_W;
	localparam int REM_W = SQRT_W + 2;

	logic              v_q    [1:NS];
	logic [REM_W-1:0]  rem_q  [1:NS];
	logic [SQRT_W-1:0] root_q [1:NS];
	logic [RAD_W-1:0]  rad_q  [1:NS];
	logic [SIDE_W-1:0] side_q [1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic              v_i;
		logic [REM_W-1:0]  rem_i;
		logic [SQRT_W-1:0] root_i;
		logic [RAD_W-1:0]  rad_i;
		logic [SIDE_W-1:0] side_i;
		logic [REM_W+1:0]  remx, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = RAD_W'(disc) << (2 * SQRT_EXTRA);
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_q[k];
			assign rem_i  = rem_q[k];
			assign root_i = root_q[k];
			assign rad_i  = rad_q[k];
			assign side_i = side_q[k];
		end

		assign remx  = {rem_i, rad_i[RAD_W-1 -: 2]};
		assign trial = {2'b0, root_i, 2'b01};
		assign ge    = (remx >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= ge ? REM_W'(remx - trial) : REM_W'(remx);
				root_q[k+1] <= {root_i[SQRT_W-2:0], ge};
				rad_q[k+1]  <= rad_i << 2;
				side_q[k+1] <= side_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_i;
			end
		end
	end

	assign out_valid = v_q[NS];
	assign root      = root_q[NS];
	assign out_side  = side_q[NS];
endmodule

/* hw/rtl/qrr_div.sv */
module qrr_div import qrr_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [30:0]       rem0,
	input  logic [31:0]       lo,
	input  logic [30:0]       divisor,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [31:0]       quot,
	output logic [SIDE_W-1:0] out_side
);
	localparam int NS = 32;

	logic              v_q   [1:NS];
	logic [30:0]       rem_q [1:NS];
	logic [31:0]       lo_q  [1:NS];
	logic [30:0]       dv_q  [1:NS];
	logic [SIDE_W-1:0] side_q[1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic              v_i;
		logic [30:0]       rem_i, dv_i;
		logic [31:0]       lo_i, r;
		logic [SIDE_W-1:0] side_i;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = rem0;
			assign lo_i   = lo;
			assign dv_i   = divisor;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_q[k];
			assign rem_i  = rem_q[k];
			assign lo_i   = lo_q[k];
			assign dv_i   = dv_q[k];
			assign side_i = side_q[k];
		end

		// shift in the next dividend bit, the quotient bit fills from the right
		assign r  = {rem_i, lo_i[31]};
		assign ge = (r >= {1'b0, dv_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= ge ? 31'(r - {1'b0, dv_i}) : r[30:0];
				lo_q[k+1]   <= {lo_i[30:0], ge};
				dv_q[k+1]   <= dv_i;
				side_q[k+1] <= side_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_i;
			end
		end
	end

	assign out_valid = v_q[NS];
	assign quot      = lo_q[NS];
	assign out_side  = side_q[NS];
endmodule

/* hw/rtl/qrr_back.sv */
module qrr_back import qrr_pkg::*; #(
	parameter int ROOT_FRAC_BITS = ROOT_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  mid_t      mid_item,
	input  logic      mid_empty,
	input  logic      out_full,
	output back_ctl_t ctl,
	output out_t      out_item
);
	localparam int DV_W = 33 + ROOT_FRAC_BITS;

	logic               en;
	logic               sq_v;
	logic [SQRT_W-1:0]  sq_root;
	logic [33:0]        sq_side;
	kind_t              sq_kind;
	logic signed [15:0] sq_a, sq_b;
	logic signed [30:0] nb;
	logic signed [32:0] nh, nl;
	logic [15:0]        a_abs;

	logic               v_s1, v_s2;
	kind_t              kind_s1, kind_s2;
	logic [31:0]        mh_s1, ml_s1;
	logic               negh_s1, negl_s1, negh_s2, negl_s2;
	logic [30:0]        ud_s1, ud_s2;
	logic [DV_W-1:0]    dvh, dvl;
	logic [30:0]        remh_s2, reml_s2;
	logic [31:0]        loh_s2, lol_s2;
	logic               earlyh_s2, earlyl_s2;

	logic               dh_v, dl_v;
	logic [31:0]        qh, ql;
	logic [3:0]         dh_side;
	logic [1:0]         dl_side;
	kind_t              fin_kind;
	logic               sath, satl;
	logic [31:0]        rh, rl;

	assign en          = !out_full;
	assign ctl.mid_pop = en && !mid_empty;

	qrr_sqrt #(.SIDE_W(34)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (!mid_empty),
		.disc      (mid_item.disc),
		.in_side   ({mid_item.kind, mid_item.a, mid_item.b}),
		.out_valid (sq_v),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	assign sq_kind = kind_t'(sq_side[33:32]);
	assign sq_a    = sq_side[31:16];
	assign sq_b    = sq_side[15:0];
	assign nb      = -{sq_b[15], sq_b, 14'b0};
	assign nh      = 33'(nb) + {2'b0, sq_root};
	assign nl      = 33'(nb) - {2'b0, sq_root};
	assign a_abs   = sq_a[15] ? 16'(-sq_a) : sq_a;

	// rounding adds half the divisor before the division
	assign dvh = (DV_W'(mh_s1) << ROOT_FRAC_BITS) + DV_W'(ud_s1 >> 1);
	assign dvl = (DV_W'(ml_s1) << ROOT_FRAC_BITS) + DV_W'(ud_s1 >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= sq_kind;
			mh_s1     <= nh[32] ? 32'(-nh) : nh[31:0];
			ml_s1     <= nl[32] ? 32'(-nl) : nl[31:0];
			negh_s1   <= nh[32] != sq_a[15];
			negl_s1   <= nl[32] != sq_a[15];
			ud_s1     <= {a_abs, 15'b0};
			kind_s2   <= kind_s1;
			negh_s2   <= negh_s1;
			negl_s2   <= negl_s1;
			ud_s2     <= ud_s1;
			// quotient of 2^32 or more clamps regardless of the low bits
			earlyh_s2 <= (dvh >> 32) >= DV_W'(ud_s1);
			earlyl_s2 <= (dvl >> 32) >= DV_W'(ud_s1);
			remh_s2   <= 31'(dvh >> 32);
			reml_s2   <= 31'(dvl >> 32);
			loh_s2    <= dvh[31:0];
			lol_s2    <= dvl[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= sq_v;
			v_s2 <= v_s1;
		end
	end

	qrr_div #(.SIDE_W(4)) u_div_high (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.rem0      (remh_s2),
		.lo        (loh_s2),
		.divisor   (ud_s2),
		.in_side   ({kind_s2, negh_s2, earlyh_s2}),
		.out_valid (dh_v),
		.quot      (qh),
		.out_side  (dh_side)
	);

	qrr_div #(.SIDE_W(2)) u_div_low (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.rem0      (reml_s2),
		.lo        (lol_s2),
		.divisor   (ud_s2),
		.in_side   ({negl_s2, earlyl_s2}),
		.out_valid (dl_v),
		.quot      (ql),
		.out_side  (dl_side)
	);

	assign fin_kind = kind_t'(dh_side[3:2]);
	assign sath = dh_side[0] || (dh_side[1] ? (qh > 32'h8000_0000) : (qh > 32'h7fff_ffff));
	assign satl = dl_side[0] || (dl_side[1] ? (ql > 32'h8000_0000) : (ql > 32'h7fff_ffff));
	assign rh = sath ? (dh_side[1] ? 32'h8000_0000 : 32'h7fff_ffff)
	                 : (dh_side[1] ? 32'(-qh) : qh);
	assign rl = satl ? (dl_side[1] ? 32'h8000_0000 : 32'h7fff_ffff)
	                 : (dl_side[1] ? 32'(-ql) : ql);

	assign ctl.out_push = en && dh_v && dl_v;

	always_comb begin
		out_item.root_kind = fin_kind;
		unique case (fin_kind)
			KIND_DOUBLE, KIND_TWO: begin
				out_item.root_high = rh;
				out_item.root_low  = rl;
				out_item.saturated = sath || satl;
			end
			default: begin
				out_item.root_high = '0;
				out_item.root_low  = '0;
				out_item.saturated = 1'b0;
			end
		endcase
	end
endmodule

/* hw/rtl/qrr_checker.sv */
module qrr_checker import qrr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input out_t result
);
	// the no-root and a-zero kinds carry zero roots and no clamp
	a_no_roots_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.root_kind == KIND_NONE || result.root_kind == KIND_A_ZERO)
		|-> result.root_high == '0 && result.root_low == '0 && !result.saturated)
		else $error("roots not zero for a kind without real roots");

	a_double_equal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.root_kind == KIND_DOUBLE |-> result.root_high == result.root_low)
		else $error("double root gives two different values");

	// a clamp flag means at least one root sits at a range limit
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.saturated
		|-> result.root_high == 32'sh7fff_ffff || result.root_high == -32'sh8000_0000
		 || result.root_low == 32'sh7fff_ffff || result.root_low == -32'sh8000_0000)
		else $error("saturated set with no root at a limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result dropped or changed");
endmodule

bind quadratic_real_roots_core qrr_checker u_qrr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
